>>> rtl/tvwap_pkg.sv
// Shared types, widths and codes of the trade run VWAP aggregator.
// Used by the channel interfaces, the divider and the top level.
`default_nettype none

package tvwap_pkg;

  localparam int TIME_W  = 48;
  localparam int TYPE_W  = 8;
  localparam int WORD_W  = 32;
  localparam int EXCH_W  = 8;
  localparam int COST_W  = 64;
  localparam int VSUM_W  = 40;
  localparam int AVG_W   = 48;

  localparam int PRICE_BITS_DEF    = 32;
  localparam int VOLUME_BITS_DEF   = 32;
  localparam int FRACTION_BITS_DEF = 16;

  localparam logic [TYPE_W-1:0] EXEC_TYPE_A = 8'd69;
  localparam logic [TYPE_W-1:0] EXEC_TYPE_B = 8'd70;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_ACCUM,
    ST_START,
    ST_POST,
    ST_DIV,
    ST_LOAD
  } fsm_state_t;

  typedef struct packed {
    logic [WORD_W-1:0] bid_price;
    logic [WORD_W-1:0] ask_price;
    logic [WORD_W-1:0] bid_volume;
    logic [WORD_W-1:0] ask_volume;
  } book_t;

  typedef struct packed {
    logic [TIME_W-1:0] ev_time;
    logic [TYPE_W-1:0] ev_type;
    logic [WORD_W-1:0] ev_volume;
    logic [WORD_W-1:0] ev_price;
    logic [EXCH_W-1:0] ev_exchange;
    logic              ev_side;
    book_t             book;
    logic              end_of_stream;
  } ev_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] run_time;
    book_t             prior;
    logic [AVG_W-1:0]  avg_price;
    logic [VSUM_W-1:0] total_volume;
    logic              is_sell;
    logic [WORD_W-1:0] extreme_price;
    logic [EXCH_W-1:0] exchange_id;
    logic              last_of_run;
  } out_rec_t;

  typedef struct packed {
    logic              start;
    logic [COST_W-1:0] dividend;
    logic [VSUM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [AVG_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> rtl/tvwap_in_if.sv
// Input channel carrying one order-book event row per request.
// Depends on tvwap_pkg for field widths.
`default_nettype none

interface tvwap_in_if;
  import tvwap_pkg::*;

  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] ev_time;
  logic [TYPE_W-1:0] ev_type;
  logic [WORD_W-1:0] ev_volume;
  logic [WORD_W-1:0] ev_price;
  logic [EXCH_W-1:0] ev_exchange;
  logic              ev_side;
  logic [WORD_W-1:0] book_bid_price;
  logic [WORD_W-1:0] book_ask_price;
  logic [WORD_W-1:0] book_bid_volume;
  logic [WORD_W-1:0] book_ask_volume;
  logic              end_of_stream;

  modport source (
    output valid, ev_time, ev_type, ev_volume, ev_price, ev_exchange, ev_side,
           book_bid_price, book_ask_price, book_bid_volume, book_ask_volume,
           end_of_stream,
    input  ready
  );

  modport sink (
    input  valid, ev_time, ev_type, ev_volume, ev_price, ev_exchange, ev_side,
           book_bid_price, book_ask_price, book_bid_volume, book_ask_volume,
           end_of_stream,
    output ready
  );

endinterface

`default_nettype wire

>>> rtl/tvwap_out_if.sv
// Result channel carrying one finished market-order run per request.
// Depends on tvwap_pkg for field widths.
`default_nettype none

interface tvwap_out_if;
  import tvwap_pkg::*;

  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] run_time;
  logic [WORD_W-1:0] prior_bid_price;
  logic [WORD_W-1:0] prior_ask_price;
  logic [WORD_W-1:0] prior_bid_volume;
  logic [WORD_W-1:0] prior_ask_volume;
  logic [AVG_W-1:0]  avg_price;
  logic [VSUM_W-1:0] total_volume;
  logic              is_sell;
  logic [WORD_W-1:0] extreme_price;
  logic [EXCH_W-1:0] exchange_id;
  logic              last_of_run;

  modport source (
    output valid, run_time, prior_bid_price, prior_ask_price, prior_bid_volume,
           prior_ask_volume, avg_price, total_volume, is_sell, extreme_price,
           exchange_id, last_of_run,
    input  ready
  );

  modport sink (
    input  valid, run_time, prior_bid_price, prior_ask_price, prior_bid_volume,
           prior_ask_volume, avg_price, total_volume, is_sell, extreme_price,
           exchange_id, last_of_run,
    output ready
  );

endinterface

`default_nettype wire

>>> rtl/tvwap_div.sv
// Shared radix-2 restoring divider that forms the saturated fixed-point average.
// Depends on tvwap_pkg for the request and response structs.
`default_nettype none

module tvwap_div #(
  parameter int FRACTION_BITS = tvwap_pkg::FRACTION_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tvwap_pkg::div_req_t req,
  output tvwap_pkg::div_rsp_t rsp
);
  import tvwap_pkg::*;

  localparam int DW    = COST_W + FRACTION_BITS;
  localparam int CNT_W = $clog2(AVG_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [VSUM_W-1:0] rem_r, rem_nxt;
  logic [VSUM_W-1:0] div_r, div_nxt;
  logic [AVG_W-1:0]  dvd_r, dvd_nxt;
  logic [AVG_W-1:0]  quo_r, quo_nxt;

  logic [DW-1:0]     dext;
  logic [VSUM_W:0]   hi_ext;
  logic              ovf;
  logic [VSUM_W:0]   trial;
  logic [VSUM_W:0]   diff;
  logic              take;

  // The quotient overflows 48 bits exactly when the bits above the low 48 of
  // the scaled dividend already reach the divisor.
  assign dext   = DW'(req.dividend) << FRACTION_BITS;
  assign hi_ext = (VSUM_W + 1)'(dext[DW-1:AVG_W]);
  assign ovf    = hi_ext >= {1'b0, req.divisor};

  assign trial = {rem_r, dvd_r[AVG_W-1]};
  assign diff  = trial - {1'b0, div_r};
  assign take  = !diff[VSUM_W];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    if (busy_r) begin
      rem_nxt = take ? diff[VSUM_W-1:0] : trial[VSUM_W-1:0];
      dvd_nxt = {dvd_r[AVG_W-2:0], 1'b0};
      quo_nxt = {quo_r[AVG_W-2:0], take};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      div_nxt = req.divisor;
      priority if (req.divisor == '0) begin
        quo_nxt  = '0;
        done_nxt = 1'b1;
      end else if (ovf) begin
        quo_nxt  = '1;
        done_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
        cnt_nxt  = CNT_W'(AVG_W);
        rem_nxt  = hi_ext[VSUM_W-1:0];
        dvd_nxt  = dext[AVG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

`ifndef SYNTHESIS
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rem_r < div_r)
    else $error("divider remainder reached the divisor");

  a_zero_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    req.start && !busy_r && req.divisor == '0 |=> done_r && quo_r == '0)
    else $error("zero divisor did not give a zero quotient at once");

  a_no_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !(busy_r && done_r))
    else $error("divider flagged done while still iterating");
`endif

endmodule

`default_nettype wire

>>> rtl/trade_run_vwap_aggregator.sv
// Top level of the trade run VWAP aggregator: run tracking, sequencer, result register.
// Depends on tvwap_pkg, tvwap_in_if, tvwap_out_if and tvwap_div.
// A row that finishes no run passes through evaluate, add or start, and post before the next
// acceptance. Each finished run also waits for the 48-step shared divider, which skips its
// steps when the divisor is zero or the average saturates, and then for the result register to be free.
// Synchronous active-low reset clears the sequencer, the run state and the book.
`default_nettype none

module trade_run_vwap_aggregator #(
  parameter int PRICE_BITS    = tvwap_pkg::PRICE_BITS_DEF,
  parameter int VOLUME_BITS   = tvwap_pkg::VOLUME_BITS_DEF,
  parameter int FRACTION_BITS = tvwap_pkg::FRACTION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  tvwap_in_if.sink    in_ch,
  tvwap_out_if.source out_ch
);
  import tvwap_pkg::*;

  localparam int PW = (PRICE_BITS < WORD_W) ? PRICE_BITS : WORD_W;
  localparam int VW = (VOLUME_BITS < WORD_W) ? VOLUME_BITS : WORD_W;
  localparam logic [WORD_W-1:0] PRICE_MASK  = WORD_W'((64'd1 << PW) - 64'd1);
  localparam logic [WORD_W-1:0] VOLUME_MASK = WORD_W'((64'd1 << VW) - 64'd1);

  fsm_state_t        state_r, state_nxt;
  ev_item_t          item_r, item_nxt;
  logic [COST_W-1:0] prod_r, prod_nxt;

  logic              in_run_r, in_run_nxt;
  logic [TIME_W-1:0] cur_time_r, cur_time_nxt;
  logic              cur_side_r, cur_side_nxt;
  logic [EXCH_W-1:0] cur_exch_r, cur_exch_nxt;
  book_t             snap_r, snap_nxt;
  book_t             prev_r, prev_nxt;
  logic [VSUM_W-1:0] vol_sum_r, vol_sum_nxt;
  logic [COST_W-1:0] cost_sum_r, cost_sum_nxt;
  logic [WORD_W-1:0] high_r, high_nxt;
  logic [WORD_W-1:0] low_r, low_nxt;

  logic              last_r, last_nxt;
  logic              final_r, final_nxt;
  out_rec_t          out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [WORD_W-1:0] vol_m;
  logic [WORD_W-1:0] price_m;
  logic              is_exec;
  logic              run_match;
  logic              out_free;
  logic [VSUM_W:0]   vsum;
  logic [COST_W:0]   csum;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  tvwap_div #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign vol_m     = item_r.ev_volume & VOLUME_MASK;
  assign price_m   = item_r.ev_price & PRICE_MASK;
  assign is_exec   = (item_r.ev_type == EXEC_TYPE_A) || (item_r.ev_type == EXEC_TYPE_B);
  assign run_match = in_run_r && is_exec && (item_r.ev_side == cur_side_r)
                     && (item_r.ev_time == cur_time_r);
  assign prod_nxt  = COST_W'(vol_m) * COST_W'(price_m);
  assign vsum      = {1'b0, vol_sum_r} + (VSUM_W + 1)'(vol_m);
  assign csum      = {1'b0, cost_sum_r} + {1'b0, prod_r};
  assign out_free  = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    in_run_nxt    = in_run_r;
    cur_time_nxt  = cur_time_r;
    cur_side_nxt  = cur_side_r;
    cur_exch_nxt  = cur_exch_r;
    snap_nxt      = snap_r;
    prev_nxt      = prev_r;
    vol_sum_nxt   = vol_sum_r;
    cost_sum_nxt  = cost_sum_r;
    high_nxt      = high_r;
    low_nxt       = low_r;
    last_nxt      = last_r;
    final_nxt     = final_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    div_req.start    = 1'b0;
    div_req.dividend = cost_sum_r;
    div_req.divisor  = vol_sum_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          item_nxt.ev_time         = in_ch.ev_time;
          item_nxt.ev_type         = in_ch.ev_type;
          item_nxt.ev_volume       = in_ch.ev_volume;
          item_nxt.ev_price        = in_ch.ev_price;
          item_nxt.ev_exchange     = in_ch.ev_exchange;
          item_nxt.ev_side         = in_ch.ev_side;
          item_nxt.book.bid_price  = in_ch.book_bid_price;
          item_nxt.book.ask_price  = in_ch.book_ask_price;
          item_nxt.book.bid_volume = in_ch.book_bid_volume;
          item_nxt.book.ask_volume = in_ch.book_ask_volume;
          item_nxt.end_of_stream   = in_ch.end_of_stream;
          state_nxt                = ST_EVAL;
        end
      end
      ST_EVAL: begin
        priority if (run_match) begin
          state_nxt = ST_ACCUM;
        end else if (in_run_r) begin
          // The open run ends here; a second result follows only when this
          // row starts a new run that the end of stream flushes at once.
          div_req.start = 1'b1;
          last_nxt      = !(item_r.end_of_stream && is_exec);
          final_nxt     = 1'b0;
          state_nxt     = ST_DIV;
        end else begin
          state_nxt = ST_START;
        end
      end
      ST_ACCUM: begin
        vol_sum_nxt  = vsum[VSUM_W] ? '1 : vsum[VSUM_W-1:0];
        cost_sum_nxt = csum[COST_W] ? '1 : csum[COST_W-1:0];
        if (price_m > high_r) begin
          high_nxt = price_m;
        end
        if (price_m < low_r) begin
          low_nxt = price_m;
        end
        state_nxt = ST_POST;
      end
      ST_START: begin
        if (is_exec) begin
          in_run_nxt   = 1'b1;
          cur_time_nxt = item_r.ev_time;
          cur_side_nxt = item_r.ev_side;
          cur_exch_nxt = item_r.ev_exchange;
          snap_nxt     = prev_r;
          vol_sum_nxt  = VSUM_W'(vol_m);
          cost_sum_nxt = prod_r;
          high_nxt     = price_m;
          low_nxt      = price_m;
        end
        state_nxt = ST_POST;
      end
      ST_POST: begin
        prev_nxt = item_r.book;
        if (item_r.end_of_stream && in_run_r) begin
          div_req.start = 1'b1;
          last_nxt      = 1'b1;
          final_nxt     = 1'b1;
          state_nxt     = ST_DIV;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (out_free) begin
          out_nxt.run_time      = cur_time_r;
          out_nxt.prior         = snap_r;
          out_nxt.avg_price     = div_rsp.quotient;
          out_nxt.total_volume  = vol_sum_r;
          out_nxt.is_sell       = cur_side_r;
          out_nxt.extreme_price = cur_side_r ? low_r : high_r;
          out_nxt.exchange_id   = cur_exch_r;
          out_nxt.last_of_run   = last_r;
          out_valid_nxt         = 1'b1;
          in_run_nxt            = 1'b0;
          state_nxt             = final_r ? ST_IDLE : ST_START;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_run_r    <= 1'b0;
      cur_time_r  <= '0;
      cur_side_r  <= 1'b0;
      cur_exch_r  <= '0;
      snap_r      <= '0;
      prev_r      <= '0;
      vol_sum_r   <= '0;
      cost_sum_r  <= '0;
      high_r      <= '0;
      low_r       <= '0;
      last_r      <= 1'b0;
      final_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_run_r    <= in_run_nxt;
      cur_time_r  <= cur_time_nxt;
      cur_side_r  <= cur_side_nxt;
      cur_exch_r  <= cur_exch_nxt;
      snap_r      <= snap_nxt;
      prev_r      <= prev_nxt;
      vol_sum_r   <= vol_sum_nxt;
      cost_sum_r  <= cost_sum_nxt;
      high_r      <= high_nxt;
      low_r       <= low_nxt;
      last_r      <= last_nxt;
      final_r     <= final_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    prod_r <= prod_nxt;
    out_r  <= out_nxt;
  end

  assign in_ch.ready = (state_r == ST_IDLE);

  assign out_ch.valid            = out_valid_r;
  assign out_ch.run_time         = out_r.run_time;
  assign out_ch.prior_bid_price  = out_r.prior.bid_price;
  assign out_ch.prior_ask_price  = out_r.prior.ask_price;
  assign out_ch.prior_bid_volume = out_r.prior.bid_volume;
  assign out_ch.prior_ask_volume = out_r.prior.ask_volume;
  assign out_ch.avg_price        = out_r.avg_price;
  assign out_ch.total_volume     = out_r.total_volume;
  assign out_ch.is_sell          = out_r.is_sell;
  assign out_ch.extreme_price    = out_r.extreme_price;
  assign out_ch.exchange_id      = out_r.exchange_id;
  assign out_ch.last_of_run      = out_r.last_of_run;

`ifndef SYNTHESIS
  a_div_start_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> (state_r == ST_EVAL || state_r == ST_POST))
    else $error("divider started outside a run-closing step");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == ST_DIV)
    else $error("divider finished while the sequencer was not waiting");

  a_accum_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ACCUM |-> in_run_r)
    else $error("row added to a run that is not open");

  a_break_then_start: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LOAD && !final_r && out_free
    |=> state_r == ST_START && !in_run_r && out_valid_r)
    else $error("closed run did not hand over to the new row");
`endif

endmodule

`default_nettype wire
